// ----- hw/rtl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising edge of clk outside reset.
`define I2CMW_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Expression must never be true at a rising edge of clk outside reset.
`define I2CMW_ASSERT_NEVER(lbl, expr, msg) \
    `I2CMW_ASSERT(lbl, !(expr), msg)

`endif

// ----- hw/rtl/i2cmw_pkg.sv -----
// ---------------------------------------------------------------------------
// i2cmw_pkg
// Types, phase codes and constants of the I2C master write engine.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package i2cmw_pkg;

    localparam int BYTE_W    = 8;
    localparam int TIMEOUT_W = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int PHASE_W    = 4;
    localparam int BITCNT_W   = 4;
    localparam int STATUS_W   = 2;

    // Phase codes of the bus sequencer.
    localparam logic [PHASE_W-1:0] PH_IDLE       = 4'd0;
    localparam logic [PHASE_W-1:0] PH_START_WAIT = 4'd1;
    localparam logic [PHASE_W-1:0] PH_START_LOW  = 4'd2;
    localparam logic [PHASE_W-1:0] PH_BIT_LOW    = 4'd3;
    localparam logic [PHASE_W-1:0] PH_BIT_HIGH   = 4'd4;
    localparam logic [PHASE_W-1:0] PH_ACK_LOW    = 4'd5;
    localparam logic [PHASE_W-1:0] PH_ACK_HIGH   = 4'd6;
    localparam logic [PHASE_W-1:0] PH_ACK_WAIT   = 4'd7;
    localparam logic [PHASE_W-1:0] PH_STOP_RISE  = 4'd8;
    localparam logic [PHASE_W-1:0] PH_STOP_END   = 4'd9;

    // Completion status codes.
    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BUSY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NACK = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_ADDRESS_BYTE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS = 1'b1;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd100;
    localparam logic [BITCNT_W-1:0]  BITS_PER_BYTE = 4'd8;

    typedef struct packed {
        logic             command;
        logic             sda_level;
        logic [BYTE_W-1:0] byte_value;
        logic             byte_is_last;
    } in_item_t;

    typedef struct packed {
        logic               scl_release;
        logic               sda_release;
        logic               byte_taken;
        logic               done_res;
        logic [STATUS_W-1:0] status;
    } out_item_t;

    typedef struct packed {
        logic [PHASE_W-1:0]   phase;
        logic [BITCNT_W-1:0]  bit_count;
        logic [BYTE_W-1:0]    shift_byte;
        logic [TIMEOUT_W-1:0] wait_count;
        logic                 final_byte_flag;
        logic [STATUS_W-1:0]  error_code;
    } seq_state_t;

    typedef struct packed {
        logic [BYTE_W-1:0]    address_byte;
        logic [TIMEOUT_W-1:0] timeout_ticks;
    } cfg_t;

endpackage

// ----- hw/rtl/i2cmw_step.sv -----
// ---------------------------------------------------------------------------
// i2cmw_step
// One bus tick of the write sequencer: next state and line drive.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module i2cmw_step (
    input  i2cmw_pkg::seq_state_t cur,
    input  i2cmw_pkg::in_item_t   item,
    input  i2cmw_pkg::cfg_t       cfg,
    output i2cmw_pkg::seq_state_t nxt,
    output i2cmw_pkg::out_item_t  res
);
    import i2cmw_pkg::*;

    logic [BITCNT_W-1:0] bit_count_inc;

    assign bit_count_inc = cur.bit_count + BITCNT_W'(1);

    always_comb
    begin
        nxt = cur;
        res = '0;
        res.scl_release = 1'b1;
        res.sda_release = 1'b1;
        unique case (cur.phase)
            PH_START_WAIT:
            begin
                if (item.sda_level)
                begin
                    res.sda_release = 1'b0;
                    nxt.phase = PH_START_LOW;
                end
                else if (cur.wait_count == '0)
                begin
                    res.done_res = 1'b1;
                    res.status = ST_BUSY;
                    nxt.phase = PH_IDLE;
                end
                else
                begin
                    nxt.wait_count = cur.wait_count - TIMEOUT_W'(1);
                end
            end
            PH_START_LOW:
            begin
                res.scl_release = 1'b0;
                res.sda_release = 1'b0;
                nxt.shift_byte = cfg.address_byte;
                nxt.bit_count = '0;
                nxt.phase = PH_BIT_LOW;
            end
            PH_BIT_LOW:
            begin
                res.scl_release = 1'b0;
                res.sda_release = cur.shift_byte[BYTE_W-1];
                nxt.phase = PH_BIT_HIGH;
            end
            PH_BIT_HIGH:
            begin
                res.sda_release = cur.shift_byte[BYTE_W-1];
                nxt.shift_byte = {cur.shift_byte[BYTE_W-2:0], 1'b0};
                nxt.bit_count = bit_count_inc;
                nxt.phase = (bit_count_inc >= BITS_PER_BYTE) ? PH_ACK_LOW : PH_BIT_LOW;
            end
            PH_ACK_LOW:
            begin
                res.scl_release = 1'b0;
                nxt.phase = PH_ACK_HIGH;
            end
            PH_ACK_HIGH:
            begin
                nxt.wait_count = cfg.timeout_ticks;
                nxt.phase = PH_ACK_WAIT;
            end
            PH_ACK_WAIT:
            begin
                if (!item.sda_level)
                begin
                    res.scl_release = 1'b0;
                    if (cur.final_byte_flag)
                    begin
                        res.sda_release = 1'b0;
                        nxt.phase = PH_STOP_RISE;
                    end
                    else
                    begin
                        // The acknowledge tick also drives the first bit of the next byte.
                        res.byte_taken = 1'b1;
                        res.sda_release = item.byte_value[BYTE_W-1];
                        nxt.final_byte_flag = item.byte_is_last;
                        nxt.shift_byte = item.byte_value;
                        nxt.bit_count = '0;
                        nxt.phase = PH_BIT_HIGH;
                    end
                end
                else if (cur.wait_count == '0)
                begin
                    res.sda_release = 1'b0;
                    nxt.error_code = ST_NACK;
                    nxt.phase = PH_STOP_RISE;
                end
                else
                begin
                    nxt.wait_count = cur.wait_count - TIMEOUT_W'(1);
                end
            end
            PH_STOP_RISE:
            begin
                res.sda_release = 1'b0;
                nxt.phase = PH_STOP_END;
            end
            PH_STOP_END:
            begin
                res.done_res = 1'b1;
                res.status = cur.error_code;
                nxt.phase = PH_IDLE;
            end
            default:
            begin
                // Idle, and any code outside the list, which falls back to idle.
                nxt.phase = PH_IDLE;
                if (item.command)
                begin
                    nxt.error_code = ST_OK;
                    nxt.final_byte_flag = 1'b0;
                    nxt.bit_count = '0;
                    nxt.wait_count = cfg.timeout_ticks;
                    nxt.phase = PH_START_WAIT;
                end
            end
        endcase
    end

endmodule

// ----- hw/rtl/i2c_master_write_bitbang_top.sv -----
// ---------------------------------------------------------------------------
// i2c_master_write_bitbang_top
// Open-drain I2C master write engine, one bus timing tick per item.
// ---------------------------------------------------------------------------
// Usage: every input item is one bus tick. It carries the sampled SDA level,
// a begin command and the next data byte with its last flag. Every item
// produces exactly one result item with the SCL and SDA release levels for
// that tick, a byte taken flag, and a done flag with its status.
// Both channels use valid and ready. An item is registered on entry, the
// sequencer step is evaluated from that register and the current state, and
// the result lands in an output register. The block takes one item per cycle
// while the receiver does not stall; the rate is set by the combinational
// sequencer step between the two registers.
// When the receiver stalls, the result stays in the output register and the
// input register still accepts one more item, after which ready drops until
// the result is taken. No tick is lost or repeated.
// Reset empties both pipeline registers, puts the sequencer in idle and loads
// the configuration defaults: address byte 0, timeout 100 ticks.
// Configuration writes (index 0 address byte, index 1 timeout ticks) take
// effect at once and are meant for when the block is idle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module i2c_master_write_bitbang_top (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         in_valid,
    output logic                                         in_ready,
    input  i2cmw_pkg::in_item_t                          in_data,
    output logic                                         out_valid,
    input  logic                                         out_ready,
    output i2cmw_pkg::out_item_t                         out_data,
    input  logic                                         cfg_wr_en,
    input  logic [i2cmw_pkg::CFG_IDX_W-1:0]              cfg_index,
    input  logic [i2cmw_pkg::CFG_DATA_W-1:0]             cfg_data
);
    import i2cmw_pkg::*;

    // Input register stage.
    logic      in_item_valid_reg;
    in_item_t  in_item_reg;

    // Output register stage.
    logic      out_valid_reg;
    out_item_t out_item_reg;

    // Sequencer state and configuration.
    seq_state_t seq_reg;
    seq_state_t seq_next;
    out_item_t  step_res;
    cfg_t       cfg_reg;

    logic advance;
    logic in_fire;

    // The registered item steps the sequencer whenever the output slot is
    // free or being emptied in this cycle.
    assign advance  = in_item_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_item_valid_reg || advance;
    assign in_fire  = in_valid && in_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;

    i2cmw_step u_step (
        .cur  (seq_reg),
        .item (in_item_reg),
        .cfg  (cfg_reg),
        .nxt  (seq_next),
        .res  (step_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_item_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            in_item_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_item_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            in_item_reg <= in_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            seq_reg       <= '{phase: PH_IDLE, default: '0};
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
            seq_reg       <= seq_next;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_item_reg <= step_res;
        end
    end

    // Configuration registers, written directly by the write port.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.address_byte  <= '0;
            cfg_reg.timeout_ticks <= TIMEOUT_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_ADDRESS_BYTE:  cfg_reg.address_byte  <= cfg_data[BYTE_W-1:0];
                CFG_TIMEOUT_TICKS: cfg_reg.timeout_ticks <= cfg_data[TIMEOUT_W-1:0];
                default:           cfg_reg <= cfg_reg;
            endcase
        end
    end

    // A non-zero status only ever comes with the done flag.
    `I2CMW_ASSERT(a_status_with_done,
        out_valid_reg |-> (out_item_reg.done_res || out_item_reg.status == ST_OK),
        "status set without done")
    // A data byte is only consumed on a tick that holds SCL low.
    `I2CMW_ASSERT(a_taken_scl_low,
        (out_valid_reg && out_item_reg.byte_taken) |-> !out_item_reg.scl_release,
        "byte taken while SCL released")
    // With both stages full and the output stalled, no further item enters.
    `I2CMW_ASSERT(a_full_no_entry,
        (in_item_valid_reg && out_valid_reg && !out_ready) |-> !in_ready,
        "input accepted while pipeline full")
    // The bit counter never runs past one byte.
    `I2CMW_ASSERT_NEVER(a_bit_count_range,
        seq_reg.bit_count > BITS_PER_BYTE,
        "bit counter out of range")

endmodule

// ----- tb/tb_i2c_master_write_bitbang_top.sv -----
// ---------------------------------------------------------------------------
// tb_i2c_master_write_bitbang_top
// Self-checking bench for the open-drain I2C master write engine. Each bus
// tick goes in as one item and comes back as one result item. A local
// copy of the sequencer predicts every result. Stimulus plays host and
// slave: begin commands, SDA release, ACK timing and data bytes, with
// random stalls on both channels.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_i2c_master_write_bitbang_top;

    import i2cmw_pkg::*;

    // Run length guard and the length of the one long receiver stall.
    localparam int LIMIT_CYCLES   = 200000;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES  = 6;
    localparam int PHASES         = 6;
    localparam int PHASE_ITEMS    = 135;

    // One row of the directed part: stimulus, plus a typed-in result where
    // the result is obvious. Rows without one are checked against the
    // predictor.
    typedef struct packed {
        in_item_t  stim;
        logic      known;
        out_item_t want;
    } dir_row_t;

    // Line levels that are easy to read off the tick sequence.
    localparam out_item_t OUT_NONE      = '0;
    localparam out_item_t OUT_IDLE      = {1'b1, 1'b1, 1'b0, 1'b0, ST_OK};
    localparam out_item_t OUT_BUSY      = {1'b1, 1'b1, 1'b0, 1'b1, ST_BUSY};
    localparam out_item_t OUT_START     = {1'b1, 1'b0, 1'b0, 1'b0, ST_OK};
    localparam out_item_t OUT_BOTH_LOW  = {1'b0, 1'b0, 1'b0, 1'b0, ST_OK};
    localparam out_item_t OUT_STOP_LOW  = {1'b1, 1'b0, 1'b0, 1'b0, ST_OK};
    localparam out_item_t OUT_NACK_DONE = {1'b1, 1'b1, 1'b0, 1'b1, ST_NACK};

    localparam int DIRECTED_ROWS = 26;

    // Directed part, run with a zero timeout and address byte 0x80.
    // Field order: command, sda_level, byte_value, byte_is_last, known, want.
    localparam dir_row_t DIRECTED [DIRECTED_ROWS] = '{
        // A begin with SDA held low. With a zero timeout the single
        // sample that follows reports bus busy, and no stop is sent.
        {1'b1, 1'b0, 8'h00, 1'b0, 1'b1, OUT_IDLE},
        {1'b1, 1'b0, 8'hFF, 1'b1, 1'b1, OUT_BUSY},
        // A second begin finds SDA high and makes a start condition.
        {1'b1, 1'b1, 8'h00, 1'b0, 1'b1, OUT_IDLE},
        {1'b0, 1'b1, 8'h3C, 1'b0, 1'b1, OUT_START},
        // A command in the middle of a transaction is ignored.
        {1'b1, 1'b0, 8'hC3, 1'b1, 1'b1, OUT_BOTH_LOW},
        // Address byte, two ticks per bit, MSB first.
        {1'b0, 1'b0, 8'h01, 1'b0, 1'b0, OUT_NONE},
        {1'b1, 1'b1, 8'h02, 1'b1, 1'b0, OUT_NONE},
        {1'b0, 1'b1, 8'h04, 1'b0, 1'b0, OUT_NONE},
        {1'b1, 1'b0, 8'h08, 1'b1, 1'b0, OUT_NONE},
        {1'b0, 1'b0, 8'h10, 1'b0, 1'b0, OUT_NONE},
        {1'b1, 1'b1, 8'h20, 1'b1, 1'b0, OUT_NONE},
        {1'b0, 1'b1, 8'h40, 1'b0, 1'b0, OUT_NONE},
        {1'b1, 1'b0, 8'h80, 1'b1, 1'b0, OUT_NONE},
        {1'b0, 1'b0, 8'hFE, 1'b0, 1'b0, OUT_NONE},
        {1'b1, 1'b1, 8'hFD, 1'b1, 1'b0, OUT_NONE},
        {1'b0, 1'b1, 8'hFB, 1'b0, 1'b0, OUT_NONE},
        {1'b1, 1'b0, 8'hF7, 1'b1, 1'b0, OUT_NONE},
        {1'b0, 1'b0, 8'hEF, 1'b0, 1'b0, OUT_NONE},
        {1'b1, 1'b1, 8'hDF, 1'b1, 1'b0, OUT_NONE},
        {1'b0, 1'b1, 8'hBF, 1'b0, 1'b0, OUT_NONE},
        {1'b1, 1'b0, 8'h7F, 1'b1, 1'b0, OUT_NONE},
        // ACK bit: SCL low, then SCL high, both with SDA released.
        {1'b0, 1'b1, 8'h55, 1'b0, 1'b0, OUT_NONE},
        {1'b1, 1'b0, 8'hAA, 1'b1, 1'b0, OUT_NONE},
        // The slave leaves SDA high. With a zero timeout that single sample
        // is a nack, and exactly one stop follows.
        {1'b1, 1'b1, 8'hFF, 1'b1, 1'b1, OUT_STOP_LOW},
        {1'b0, 1'b0, 8'h00, 1'b0, 1'b1, OUT_STOP_LOW},
        {1'b0, 1'b0, 8'h00, 1'b0, 1'b1, OUT_NACK_DONE}
    };

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_ready;
    out_item_t out_data;
    logic      cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    i2c_master_write_bitbang_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Predicted sequencer state and register copy, advanced on every
    // accepted tick.
    seq_state_t seq_shadow;
    cfg_t       cfg_shadow;

    // Line levels still owed by the block, oldest first.
    out_item_t  pending_lines[$];

    // Plan of the transaction being played out by the stimulus side.
    int start_delay;
    int ack_delay;
    int bytes_total;
    int bytes_sent;

    // Gap control. A burst flag turns off idling for that side. The
    // hold request asks the receiver for one long stall.
    bit tx_burst;
    bit rx_burst;
    bit rx_hold_req;

    // Bookkeeping for the checks and the closing summary.
    int        ticks_accepted;
    int        results_checked;
    int        mismatches;
    int        stray_results;
    int        settings_used;
    int        ends_ok;
    int        ends_busy;
    int        ends_nack;
    int        bytes_taken;
    out_item_t want_lines;

    // 10 ns clock.
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Advance the predicted sequencer by one tick and return the line levels
    // that the block must produce for it.
    function automatic out_item_t bus_tick(input in_item_t tick);
        out_item_t lines;
        lines = OUT_IDLE;
        case (seq_shadow.phase)
            PH_START_WAIT:
            begin
                if (tick.sda_level)
                begin
                    lines.sda_release = 1'b0;
                    seq_shadow.phase  = PH_START_LOW;
                end
                else if (seq_shadow.wait_count == '0)
                begin
                    lines.done_res   = 1'b1;
                    lines.status     = ST_BUSY;
                    seq_shadow.phase = PH_IDLE;
                end
                else
                begin
                    seq_shadow.wait_count = seq_shadow.wait_count - 1'b1;
                end
            end
            PH_START_LOW:
            begin
                lines.scl_release     = 1'b0;
                lines.sda_release     = 1'b0;
                seq_shadow.shift_byte = cfg_shadow.address_byte;
                seq_shadow.bit_count  = '0;
                seq_shadow.phase      = PH_BIT_LOW;
            end
            PH_BIT_LOW:
            begin
                lines.scl_release = 1'b0;
                lines.sda_release = seq_shadow.shift_byte[BYTE_W-1];
                seq_shadow.phase  = PH_BIT_HIGH;
            end
            PH_BIT_HIGH:
            begin
                lines.sda_release     = seq_shadow.shift_byte[BYTE_W-1];
                seq_shadow.shift_byte = seq_shadow.shift_byte << 1;
                seq_shadow.bit_count  = seq_shadow.bit_count + 1'b1;
                seq_shadow.phase      = (seq_shadow.bit_count >= BITS_PER_BYTE) ?
                                        PH_ACK_LOW : PH_BIT_LOW;
            end
            PH_ACK_LOW:
            begin
                lines.scl_release = 1'b0;
                seq_shadow.phase  = PH_ACK_HIGH;
            end
            PH_ACK_HIGH:
            begin
                seq_shadow.wait_count = cfg_shadow.timeout_ticks;
                seq_shadow.phase      = PH_ACK_WAIT;
            end
            PH_ACK_WAIT:
            begin
                if (!tick.sda_level)
                begin
                    // The ACK tick already pulls SCL low for what follows.
                    lines.scl_release = 1'b0;
                    if (seq_shadow.final_byte_flag)
                    begin
                        lines.sda_release = 1'b0;
                        seq_shadow.phase  = PH_STOP_RISE;
                    end
                    else
                    begin
                        lines.byte_taken           = 1'b1;
                        seq_shadow.final_byte_flag = tick.byte_is_last;
                        seq_shadow.shift_byte      = tick.byte_value;
                        seq_shadow.bit_count       = '0;
                        lines.sda_release          = tick.byte_value[BYTE_W-1];
                        seq_shadow.phase           = PH_BIT_HIGH;
                    end
                end
                else if (seq_shadow.wait_count == '0)
                begin
                    seq_shadow.error_code = ST_NACK;
                    lines.sda_release     = 1'b0;
                    seq_shadow.phase      = PH_STOP_RISE;
                end
                else
                begin
                    seq_shadow.wait_count = seq_shadow.wait_count - 1'b1;
                end
            end
            PH_STOP_RISE:
            begin
                lines.sda_release = 1'b0;
                seq_shadow.phase  = PH_STOP_END;
            end
            PH_STOP_END:
            begin
                lines.done_res   = 1'b1;
                lines.status     = seq_shadow.error_code;
                seq_shadow.phase = PH_IDLE;
            end
            default:
            begin
                seq_shadow.phase = PH_IDLE;
                if (tick.command)
                begin
                    seq_shadow.error_code      = ST_OK;
                    seq_shadow.final_byte_flag = 1'b0;
                    seq_shadow.bit_count       = '0;
                    seq_shadow.wait_count      = cfg_shadow.timeout_ticks;
                    seq_shadow.phase           = PH_START_WAIT;
                end
            end
        endcase
        return lines;
    endfunction

    // How many ticks the slave side lets pass before it answers. With short
    // timeouts it sometimes never answers, which gives bus busy or a nack.
    // Sometimes it answers on the very last sample that is allowed.
    function automatic int pick_delay();
        int limit;
        int roll;
        limit = int'(cfg_shadow.timeout_ticks);
        roll  = $urandom_range(0, 99);
        if (limit <= 300 && roll < 10)
            return limit + 1;
        if (limit <= 300 && roll < 18)
            return limit;
        return $urandom_range(0, (limit < 3) ? limit : 3);
    endfunction

    // Build the next tick from the predicted phase. Fields that the current
    // phase ignores carry random values. A small share of SDA samples is
    // flipped to break up the sequences.
    function automatic in_item_t next_tick(input bit allow_begin);
        in_item_t tick;
        int       elapsed;
        tick.command      = 1'($urandom_range(0, 1));
        tick.sda_level    = 1'($urandom_range(0, 1));
        tick.byte_value   = 8'($urandom);
        tick.byte_is_last = 1'($urandom_range(0, 1));
        elapsed = int'(cfg_shadow.timeout_ticks) - int'(seq_shadow.wait_count);
        case (seq_shadow.phase)
            PH_START_WAIT:
                tick.sda_level = (elapsed >= start_delay);
            PH_ACK_HIGH:
                ack_delay = pick_delay();
            PH_ACK_WAIT:
                tick.sda_level = (elapsed < ack_delay);
            PH_START_LOW, PH_BIT_LOW, PH_BIT_HIGH, PH_ACK_LOW, PH_STOP_RISE,
            PH_STOP_END:
                ;
            default:
            begin
                tick.command = allow_begin && ($urandom_range(0, 3) != 0);
                if (tick.command)
                begin
                    start_delay = pick_delay();
                    bytes_total = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 4) : 1;
                    bytes_sent  = 0;
                end
            end
        endcase
        if ($urandom_range(0, 49) == 0)
            tick.sda_level = ~tick.sda_level;
        // A data byte goes in on the tick that sees the ACK. Mark the last
        // byte of the plan.
        if (seq_shadow.phase == PH_ACK_WAIT && !tick.sda_level &&
            !seq_shadow.final_byte_flag)
        begin
            bytes_sent++;
            tick.byte_is_last = (bytes_sent >= bytes_total);
        end
        return tick;
    endfunction

    // Offer one tick after a random gap and hold it until it is accepted.
    // At the accepting edge the predictor advances and the owed result is
    // queued. A typed-in result takes the place of the prediction where the
    // row gives one.
    task automatic send_tick(input in_item_t tick, input logic known, input out_item_t want);
        int        gap;
        out_item_t lines;
        gap = tx_burst ? 0 : $urandom_range(0, 19);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= tick;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        lines = bus_tick(tick);
        pending_lines.push_back(known ? want : lines);
        ticks_accepted++;
    endtask

    // Stop offering and wait until every owed result has come back, then let
    // the two pipeline registers settle.
    task automatic drain_pipeline();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_lines.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One register write, applied to the local copy at the same time.
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] index, input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        if (index == CFG_ADDRESS_BYTE)
            cfg_shadow.address_byte = value[BYTE_W-1:0];
        else
            cfg_shadow.timeout_ticks = value[TIMEOUT_W-1:0];
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Receiver side: a random stall before each result, none in burst
    // phases, and one long stall when asked. During the long stall the
    // sender keeps offering, so the block fills up and drops in_ready.
    initial
    begin : receiver
        int gap;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            gap = rx_burst ? 0 : $urandom_range(0, 19);
            if (rx_hold_req)
            begin
                gap         = RX_HOLD_CYCLES;
                rx_hold_req = 1'b0;
            end
            @(negedge clk);
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!(out_valid && out_ready))
                @(posedge clk);
        end
    end

    // Result checker: every accepted result is compared field by field
    // with the oldest owed result.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_lines.size() == 0)
            begin
                stray_results++;
                if (stray_results <= 10)
                    $display("%0t: result with no tick owed: scl=%b sda=%b taken=%b done=%b st=%0d",
                             $time, out_data.scl_release, out_data.sda_release,
                             out_data.byte_taken, out_data.done_res, out_data.status);
            end
            else
            begin
                want_lines = pending_lines.pop_front();
                results_checked++;
                if (out_data.scl_release !== want_lines.scl_release ||
                    out_data.sda_release !== want_lines.sda_release ||
                    out_data.byte_taken  !== want_lines.byte_taken  ||
                    out_data.done_res    !== want_lines.done_res    ||
                    out_data.status      !== want_lines.status)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result %0d mismatch: want scl=%b sda=%b taken=%b done=%b st=%0d, got scl=%b sda=%b taken=%b done=%b st=%0d",
                                 $time, results_checked,
                                 want_lines.scl_release, want_lines.sda_release,
                                 want_lines.byte_taken, want_lines.done_res, want_lines.status,
                                 out_data.scl_release, out_data.sda_release,
                                 out_data.byte_taken, out_data.done_res, out_data.status);
                end
                if (want_lines.byte_taken)
                    bytes_taken++;
                if (want_lines.done_res)
                begin
                    if (want_lines.status == ST_OK)
                        ends_ok++;
                    else if (want_lines.status == ST_BUSY)
                        ends_busy++;
                    else
                        ends_nack++;
                end
            end
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial
    begin : watchdog
        repeat (LIMIT_CYCLES) @(posedge clk);
        $display("i2c_master_write_bitbang_top verification failed");
        $finish;
    end

    // Main sequence: reset, directed rows, then several random phases with
    // different register settings. Each phase ends on an idle sequencer.
    initial
    begin : stimulus
        int          p;
        int          i;
        int          r;
        logic [7:0]  addr;
        logic [15:0] tmo;

        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_data     = '0;
        cfg_wr_en   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        tx_burst    = 1'b0;
        rx_burst    = 1'b0;
        rx_hold_req = 1'b0;
        start_delay = 0;
        ack_delay   = 0;
        bytes_total = 1;
        bytes_sent  = 0;

        // Local copy starts from the reset state.
        seq_shadow       = '0;
        seq_shadow.phase = PH_IDLE;
        cfg_shadow.address_byte  = 8'h00;
        cfg_shadow.timeout_ticks = TIMEOUT_RESET;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part: zero timeout and an address with only the MSB set.
        // The upper data bits of the address write are junk and must be
        // dropped by the block.
        cfg_write(CFG_TIMEOUT_TICKS, 16'h0000);
        cfg_write(CFG_ADDRESS_BYTE, {8'hA5, 8'h80});
        settings_used++;
        for (r = 0; r < DIRECTED_ROWS; r++)
            send_tick(DIRECTED[r].stim, DIRECTED[r].known, DIRECTED[r].want);

        // Random phases. The first one restores the reset values. Others
        // cover the zero and full-scale timeout, and one-tick and short
        // windows.
        for (p = 0; p < PHASES; p++)
        begin
            addr = 8'($urandom);
            case (p)
                0:
                begin
                    addr = 8'h00;
                    tmo  = TIMEOUT_RESET;
                end
                1:
                begin
                    addr = 8'hFF;
                    tmo  = 16'h0000;
                end
                2:       tmo = 16'h0001;
                3:       tmo = 16'hFFFF;
                4:       tmo = 16'h0003;
                default: tmo = 16'($urandom_range(4, 40));
            endcase
            drain_pipeline();
            cfg_write(CFG_ADDRESS_BYTE, {8'($urandom), addr});
            cfg_write(CFG_TIMEOUT_TICKS, tmo);
            settings_used++;
            tx_burst = (p == 2 || p == 3);
            rx_burst = (p == 3 || p == 4);
            for (i = 0; i < PHASE_ITEMS; i++)
            begin
                // One long receiver stall while the sender keeps offering.
                if (p == 2 && i == 30)
                    rx_hold_req = 1'b1;
                send_tick(next_tick(1'b1), 1'b0, OUT_NONE);
            end
            // Let the open transaction run to its end before the next write.
            while (seq_shadow.phase != PH_IDLE)
                send_tick(next_tick(1'b0), 1'b0, OUT_NONE);
        end

        drain_pipeline();

        $display("Covered %0d ticks over %0d register settings: %0d clean writes, %0d bus busy, %0d nacks, %0d data bytes.",
                 ticks_accepted, settings_used, ends_ok, ends_busy, ends_nack, bytes_taken);
        $display("Checked %0d results, %0d mismatches, %0d results with no tick owed.",
                 results_checked, mismatches, stray_results);
        if (mismatches == 0 && stray_results == 0 && pending_lines.size() == 0)
            $display("i2c_master_write_bitbang_top verification clean");
        else
            $display("i2c_master_write_bitbang_top verification failed");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/i2cmw_pkg.sv
hw/rtl/i2cmw_step.sv
hw/rtl/i2c_master_write_bitbang_top.sv
tb/tb_i2c_master_write_bitbang_top.sv
